FILE: src/rwmf_pkg.sv
// ----------------------------------------------------------------------------
// rwmf_pkg: shared types and constants of the RGB window median filter
// Holds the job descriptor passed from front to back, the frame dimensions
// and the register map of the configuration port.
// ----------------------------------------------------------------------------
package rwmf_pkg;

  localparam int MAX_WINDOW_DEF = 15;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // Row and column indexes below 4096, counters up to 4096.
  localparam int POS_W   = 12;
  localparam int CNT_W   = 13;
  localparam int SLOT_W  = 4;
  localparam int REACH_W = 3;
  localparam int PIX_W   = 24;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]   width;
    logic [CNT_W-1:0]   height;
    logic [REACH_W-1:0] reach;
  } dims_t;

  typedef struct packed {
    logic [POS_W-1:0]  r0;
    logic [POS_W-1:0]  r1;
    logic [POS_W-1:0]  c0;
    logic [POS_W-1:0]  c1;
    logic [SLOT_W-1:0] slot0;
    logic              last;
  } job_t;

  // Sample counts toward the lower half at bit b under the current prefix.
  function automatic logic radix_zero(input logic [7:0] s, input logic [7:0] prefix,
                                      input logic [2:0] b);
    logic [7:0] mask;
    mask = 8'hFE << b;
    return (((s ^ prefix) & mask) == 8'h00) && !s[b];
  endfunction

endpackage

FILE: src/rwmf_line_store.sv
// ----------------------------------------------------------------------------
// rwmf_line_store: ring of image rows
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rwmf_line_store #(
  parameter int DEPTH = 16 * 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [rwmf_pkg::PIX_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [rwmf_pkg::PIX_W-1:0] rdata_o
);

  logic [rwmf_pkg::PIX_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/rwmf_job_fifo.sv
// ----------------------------------------------------------------------------
// rwmf_job_fifo: two-entry job queue
// Decouples the raster front from the median back.
// ----------------------------------------------------------------------------
module rwmf_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rwmf_pkg::job_t job_i,
  input  logic           pop_i,
  output rwmf_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);

  rwmf_pkg::job_t ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: src/rwmf_front.sv
// ----------------------------------------------------------------------------
// rwmf_front: raster tracking and job issue
// Writes pixels into the line store, tracks the next output position and
// issues a window job once every sample of that window has arrived.
// ----------------------------------------------------------------------------
module rwmf_front #(
  parameter int MAX_WINDOW = rwmf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = rwmf_pkg::MAX_WIDTH_DEF,
  parameter int RING_ROWS  = MAX_WINDOW + 1,
  parameter int AW         = $clog2(RING_ROWS * MAX_WIDTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  rwmf_pkg::dims_t            dims_i,
  input  logic                       in_valid_i,
  input  logic                       opcode_i,
  input  logic [rwmf_pkg::PIX_W-1:0] pixel_i,
  output logic                       in_stall_o,
  input  logic                       back_copy_i,
  input  logic                       fifo_full_i,
  input  logic                       fifo_empty_i,
  output logic                       push_o,
  output rwmf_pkg::job_t             job_o,
  output logic                       we_o,
  output logic [AW-1:0]              waddr_o,
  output logic [rwmf_pkg::PIX_W-1:0] wdata_o
);

  localparam int CW = rwmf_pkg::CNT_W;
  localparam int PW = rwmf_pkg::POS_W;
  localparam int SW = rwmf_pkg::SLOT_W;
  localparam logic [SW-1:0] SLOT_LAST = SW'(RING_ROWS - 1);

  logic [CW-1:0] in_row_q, in_row_d;
  logic [PW-1:0] in_col_q, in_col_d;
  logic [SW-1:0] in_slot_q, in_slot_d;
  logic [PW-1:0] orow_q, orow_d, ocol_q, ocol_d;
  logic [SW-1:0] oslot_q, oslot_d;

  logic          in_img, accept, write_px, skip, ready;
  logic [CW-1:0] reach_ext, orow_ext, ocol_ext, nr, nc, row_nx, col_nx;
  logic [PW-1:0] r0, c0;
  logic [SW:0]   dr, slot_sum;

  assign in_img   = in_row_q < dims_i.height;
  assign accept   = in_valid_i && !in_stall_o;
  assign write_px = in_img && !opcode_i;
  assign skip     = in_img && opcode_i;

  // Hold pixels while a job must read the store; all beats if full.
  assign in_stall_o = fifo_full_i || ((!fifo_empty_i || back_copy_i) && in_img);

  assign we_o    = accept && write_px;
  assign waddr_o = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign wdata_o = pixel_i;

  always_comb begin
    reach_ext = CW'(dims_i.reach);
    orow_ext  = CW'(orow_q);
    ocol_ext  = CW'(ocol_q);
    row_nx    = in_row_q;
    col_nx    = CW'(in_col_q);
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    in_slot_d = in_slot_q;
    if (write_px) begin
      if (CW'(in_col_q) + CW'(1) == dims_i.width) begin
        row_nx    = in_row_q + CW'(1);
        col_nx    = '0;
        in_slot_d = (in_slot_q == SLOT_LAST) ? '0 : in_slot_q + SW'(1);
      end else begin
        col_nx = CW'(in_col_q) + CW'(1);
      end
      in_row_d = row_nx;
      in_col_d = PW'(col_nx);
    end

    nr = (orow_ext + reach_ext > dims_i.height - CW'(1)) ? dims_i.height - CW'(1)
                                                         : orow_ext + reach_ext;
    nc = (ocol_ext + reach_ext > dims_i.width - CW'(1)) ? dims_i.width - CW'(1)
                                                        : ocol_ext + reach_ext;
    ready = !skip && (row_nx >= dims_i.height || row_nx > nr ||
                      (row_nx == nr && col_nx > nc));

    r0 = (orow_q >= PW'(dims_i.reach)) ? orow_q - PW'(dims_i.reach) : '0;
    c0 = (ocol_q >= PW'(dims_i.reach)) ? ocol_q - PW'(dims_i.reach) : '0;
    dr = (SW + 1)'(orow_q - r0);
    slot_sum = ({1'b0, oslot_q} >= dr) ? {1'b0, oslot_q} - dr
                                       : {1'b0, oslot_q} + (SW + 1)'(RING_ROWS) - dr;

    job_o.r0    = r0;
    job_o.r1    = PW'(nr);
    job_o.c0    = c0;
    job_o.c1    = PW'(nc);
    job_o.slot0 = SW'(slot_sum);
    job_o.last  = (orow_ext == dims_i.height - CW'(1)) &&
                  (ocol_ext == dims_i.width - CW'(1));

    orow_d  = orow_q;
    ocol_d  = ocol_q;
    oslot_d = oslot_q;
    if (ocol_ext + CW'(1) == dims_i.width) begin
      ocol_d  = '0;
      orow_d  = orow_q + PW'(1);
      oslot_d = (oslot_q == SLOT_LAST) ? '0 : oslot_q + SW'(1);
    end else begin
      ocol_d = ocol_q + PW'(1);
    end
  end

  assign push_o = accept && ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      in_slot_q <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      oslot_q   <= '0;
    end else if (restart_i || (push_o && job_o.last)) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      in_slot_q <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      oslot_q   <= '0;
    end else if (accept && !skip) begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      in_slot_q <= in_slot_d;
      if (ready) begin
        orow_q  <= orow_d;
        ocol_q  <= ocol_d;
        oslot_q <= oslot_d;
      end
    end
  end

endmodule

FILE: src/rwmf_back.sv
// ----------------------------------------------------------------------------
// rwmf_back: window gather and radix median
// Copies the window out of the line store, then settles the three channel
// medians one bit per pass over the stored window.
// ----------------------------------------------------------------------------
module rwmf_back #(
  parameter int MAX_WINDOW = rwmf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = rwmf_pkg::MAX_WIDTH_DEF,
  parameter int RING_ROWS  = MAX_WINDOW + 1,
  parameter int AW         = $clog2(RING_ROWS * MAX_WIDTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rwmf_pkg::job_t             job_i,
  input  logic                       fifo_empty_i,
  output logic                       pop_o,
  output logic                       copy_o,
  output logic [AW-1:0]              raddr_o,
  input  logic [rwmf_pkg::PIX_W-1:0] rdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic                       last_o
);

  localparam int WIN_N = MAX_WINDOW * MAX_WINDOW;
  localparam int NW    = $clog2(WIN_N + 1);
  localparam int IW    = $clog2(WIN_N);
  localparam int PW    = rwmf_pkg::POS_W;
  localparam int SW    = rwmf_pkg::SLOT_W;
  localparam logic [SW-1:0] SLOT_LAST = SW'(RING_ROWS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_COPY, S_SETTLE, S_SCAN, S_RESOLVE, S_OUT
  } state_e;

  state_e            state_q;
  rwmf_pkg::job_t    job_q;
  logic [PW-1:0]     row_q, col_q;
  logic [SW-1:0]     slot_q;
  logic [NW-1:0]     n_q;
  logic              cap_v_q;
  logic [IW-1:0]     cap_idx_q;
  logic [IW-1:0]     idx_q;
  logic [rwmf_pkg::PIX_W-1:0] win_q [WIN_N];
  logic [rwmf_pkg::PIX_W-1:0] rd_q;
  logic              rd_v_q;
  logic [2:0]        bit_q;
  logic [7:0]        prefix_q [3];
  logic [NW-1:0]     k_q [3];
  logic [NW-1:0]     cnt_q [3];
  logic [NW-1:0]     tot [3];
  logic [2:0]        hit;
  logic [7:0]        prefix_out_q [3];

  assign pop_o   = (state_q == S_IDLE) && !fifo_empty_i;
  assign copy_o  = state_q == S_COPY;
  assign raddr_o = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(col_q);
  assign red_o   = prefix_out_q[0];
  assign green_o = prefix_out_q[1];
  assign blue_o  = prefix_out_q[2];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      hit[ch] = rd_v_q && rwmf_pkg::radix_zero(rd_q[(2 - ch) * 8 +: 8], prefix_q[ch], bit_q);
      tot[ch] = cnt_q[ch] + NW'(hit[ch]);
    end
  end

  // Window store: written by the gather, read once per scan step.
  always_ff @(posedge clk_i) begin
    if (cap_v_q) begin
      win_q[cap_idx_q] <= rdata_i;
    end
    rd_q <= win_q[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_o || !out_stall_i)) begin
      prefix_out_q <= prefix_q;
      last_o       <= job_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_v_q     <= 1'b0;
      rd_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
      job_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      slot_q      <= '0;
      n_q         <= '0;
      cap_idx_q   <= '0;
      idx_q       <= '0;
      bit_q       <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        prefix_q[ch] <= '0;
        k_q[ch]      <= '0;
        cnt_q[ch]    <= '0;
      end
    end else begin
      cap_v_q   <= state_q == S_COPY;
      cap_idx_q <= IW'(n_q);
      rd_v_q    <= state_q == S_SCAN;
      if (!out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!fifo_empty_i) begin
            job_q   <= job_i;
            row_q   <= job_i.r0;
            col_q   <= job_i.c0;
            slot_q  <= job_i.slot0;
            n_q     <= '0;
            state_q <= S_COPY;
          end
        end
        S_COPY: begin
          n_q <= n_q + NW'(1);
          if (col_q == job_q.c1) begin
            col_q <= job_q.c0;
            if (row_q == job_q.r1) begin
              state_q <= S_SETTLE;
            end else begin
              row_q  <= row_q + PW'(1);
              slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SW'(1);
            end
          end else begin
            col_q <= col_q + PW'(1);
          end
        end
        S_SETTLE: begin
          idx_q <= '0;
          bit_q <= 3'd7;
          for (int ch = 0; ch < 3; ch++) begin
            prefix_q[ch] <= '0;
            k_q[ch]      <= n_q >> 1;
            cnt_q[ch]    <= '0;
          end
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          cnt_q <= tot;
          if (NW'(idx_q) == n_q - NW'(1)) begin
            idx_q   <= '0;
            state_q <= S_RESOLVE;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_RESOLVE: begin
          // Pick the half that holds rank k, drop the other one.
          for (int ch = 0; ch < 3; ch++) begin
            cnt_q[ch] <= '0;
            if (k_q[ch] >= tot[ch]) begin
              prefix_q[ch][bit_q] <= 1'b1;
              k_q[ch]             <= k_q[ch] - tot[ch];
            end
          end
          if (bit_q == 3'd0) begin
            state_q <= S_OUT;
          end else begin
            bit_q   <= bit_q - 3'd1;
            state_q <= S_SCAN;
          end
        end
        S_OUT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/rgb_window_median_filter_top.sv
// ----------------------------------------------------------------------------
// rgb_window_median_filter_top: streaming per-channel window median
// Raster-order RGB in, per-pixel window median out, APB configuration.
// ----------------------------------------------------------------------------
// Feed one image in raster order; each beat on the input carries a pixel
// (opcode 0) or a flush (opcode 1). Every result is the per-channel median
// of the square window around one output pixel, clipped at the image edges,
// taking element n/2 of the n samples in ascending order. A result leaves as
// soon as its window is complete, at most one per input beat, in raster
// order; send flush beats after the last pixel to drain the final rows, and
// last_pixel marks the image's final result. A flush inside the image is
// dropped and a pixel past the image end counts as a flush. Results come from
// the back end, which first gathers the window of n samples from the row
// store over its single read port, then makes eight counting passes over the
// window, one per result bit. The front end queues up to two jobs and keeps
// accepting flushes while it has room, but holds new pixels until pending
// jobs have gathered their windows. A write to any listed register restarts
// the image at its first pixel; write only while the block is idle. The
// registers: 0x0 window edge, 0x4 width, 0x8 height.
// ----------------------------------------------------------------------------
module rgb_window_median_filter_top #(
  parameter int MAX_WINDOW = rwmf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = rwmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rwmf_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        last_pixel_o
);

  localparam int RING_ROWS = MAX_WINDOW + 1;
  localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = rwmf_pkg::CNT_W;
  localparam logic [2:0] REACH_MAX = 3'(MAX_WINDOW / 2);

  logic [3:0]  win_q;
  logic [11:0] width_q, height_q;
  logic        cfg_wr, restart;

  rwmf_pkg::dims_t dims;
  rwmf_pkg::job_t  push_job, head_job;
  logic            push, pop, fifo_full, fifo_empty, back_copy, we;
  logic [AW-1:0]   waddr, raddr;
  logic [rwmf_pkg::PIX_W-1:0] wdata, rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register bank; a write to a listed register restarts the raster.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= 4'd3;
      width_q  <= 12'd640;
      height_q <= 12'd480;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rwmf_pkg::REG_WINDOW: win_q    <= pwdata[3:0];
        rwmf_pkg::REG_WIDTH:  width_q  <= pwdata[11:0];
        rwmf_pkg::REG_HEIGHT: height_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    case (paddr[3:2])
      rwmf_pkg::REG_WINDOW: begin
        prdata  = 32'(win_q);
        restart = cfg_wr;
      end
      rwmf_pkg::REG_WIDTH: begin
        prdata  = 32'(width_q);
        restart = cfg_wr;
      end
      rwmf_pkg::REG_HEIGHT: begin
        prdata  = 32'(height_q);
        restart = cfg_wr;
      end
      default: prdata = '0;
    endcase
  end

  // Clamp the dimensions; an even edge acts as the next odd one.
  always_comb begin
    if (width_q == '0) dims.width = CW'(1);
    else if (CW'(width_q) > CW'(MAX_WIDTH)) dims.width = CW'(MAX_WIDTH);
    else dims.width = CW'(width_q);
    if (height_q == '0) dims.height = CW'(1);
    else if (CW'(height_q) > CW'(MAX_HEIGHT)) dims.height = CW'(MAX_HEIGHT);
    else dims.height = CW'(height_q);
    dims.reach = (win_q[3:1] > REACH_MAX) ? REACH_MAX : win_q[3:1];
  end

  rwmf_front #(
    .MAX_WINDOW(MAX_WINDOW), .MAX_WIDTH(MAX_WIDTH), .RING_ROWS(RING_ROWS), .AW(AW)
  ) u_front (
    .clk_i, .rst_ni,
    .restart_i   (restart),
    .dims_i      (dims),
    .in_valid_i,
    .opcode_i,
    .pixel_i     ({red_in_i, green_in_i, blue_in_i}),
    .in_stall_o,
    .back_copy_i (back_copy),
    .fifo_full_i (fifo_full),
    .fifo_empty_i(fifo_empty),
    .push_o      (push),
    .job_o       (push_job),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata)
  );

  rwmf_line_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i,
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  rwmf_job_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .full_o (fifo_full),
    .empty_o(fifo_empty)
  );

  rwmf_back #(
    .MAX_WINDOW(MAX_WINDOW), .MAX_WIDTH(MAX_WIDTH), .RING_ROWS(RING_ROWS), .AW(AW)
  ) u_back (
    .clk_i, .rst_ni,
    .job_i       (head_job),
    .fifo_empty_i(fifo_empty),
    .pop_o       (pop),
    .copy_o      (back_copy),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .out_valid_o,
    .out_stall_i,
    .red_o       (red_out_o),
    .green_o     (green_out_o),
    .blue_o      (blue_out_o),
    .last_o      (last_pixel_o)
  );

endmodule

FILE: src/rwmf_checker.sv
// ----------------------------------------------------------------------------
// rwmf_port_checks: port-level checks of the median filter
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module rwmf_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pready,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o,
  input logic       last_pixel_o
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_out_o) &&
      $stable(green_out_o) && $stable(blue_out_o) && $stable(last_pixel_o))
    else $error("stalled result changed");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind rgb_window_median_filter_top rwmf_port_checks u_rwmf_port_checks (
  .clk_i, .rst_ni, .pready, .out_valid_o, .out_stall_i,
  .red_out_o, .green_out_o, .blue_out_o, .last_pixel_o
);
